// File: rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
// With SYNTH defined, every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// A condition that must never hold on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/fpfa_pkg.sv
package fpfa_pkg;

	// Field widths of the request and response channels.
	localparam int ACTION_W = 1;
	localparam int SLOT_W   = 4;
	localparam int VALUE_W  = 16;
	localparam int MODE_W   = 2;

	// Request actions.
	localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b1;

	// Fit rules. Bit 1 set selects worst fit, so the unused code acts as worst fit.
	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

	typedef logic [MODE_W-1:0] fit_mode_t;

endpackage

// File: rtl/fpfa_req_if.sv
interface fpfa_req_if;
	import fpfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [SLOT_W-1:0]   slot_index;
	logic [VALUE_W-1:0]  size_value;

	modport source (output valid, output action, output slot_index, output size_value,
		input ready);
	modport sink (input valid, input action, input slot_index, input size_value,
		output ready);
endinterface

// File: rtl/fpfa_rsp_if.sv
interface fpfa_rsp_if;
	import fpfa_pkg::*;

	logic               valid;
	logic               ready;
	logic               granted;
	logic [SLOT_W-1:0]  block_index;
	logic [VALUE_W-1:0] fragment;

	modport source (output valid, output granted, output block_index, output fragment,
		input ready);
	modport sink (input valid, input granted, input block_index, input fragment,
		output ready);
endinterface

// File: rtl/fpfa_cell.sv
module fpfa_cell #(
	parameter int IDX_W     = 4,
	parameter int SIZE_BITS = 16,
	parameter int MY_IDX    = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Load of this table row.
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_idx,
	input  logic [SIZE_BITS-1:0] wr_size,
	// Commit of a grant.
	input  logic                 commit_en,
	input  logic [IDX_W-1:0]     commit_idx,
	// Request size and fit rule, stable while a scan runs.
	input  logic [SIZE_BITS-1:0] req_size,
	input  fpfa_pkg::fit_mode_t  mode,
	// Candidate handed in from the previous cell.
	input  logic                 in_valid,
	input  logic                 in_found,
	input  logic [IDX_W-1:0]     in_pick,
	input  logic [SIZE_BITS-1:0] in_psize,
	// Candidate handed on to the next cell.
	output logic                 out_valid,
	output logic                 out_found,
	output logic [IDX_W-1:0]     out_pick,
	output logic [SIZE_BITS-1:0] out_psize
);
	import fpfa_pkg::*;

	localparam logic [IDX_W-1:0] OWN_IDX = IDX_W'(MY_IDX);

	logic [SIZE_BITS-1:0] size_q;
	logic                 loaded_q;
	logic                 used_q;
	logic                 fits;
	logic                 take;
	logic                 valid_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] psize_q;

	// The row's size needs no reset: it is read only once the row is loaded.
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == OWN_IDX) begin
			size_q <= wr_size;
		end
	end

	// Loaded and used marks; a load frees the row again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			used_q   <= 1'b0;
		end else if (wr_en && wr_idx == OWN_IDX) begin
			loaded_q <= 1'b1;
			used_q   <= 1'b0;
		end else if (commit_en && commit_idx == OWN_IDX) begin
			used_q <= 1'b1;
		end
	end

	// This row replaces the candidate if it fits and beats it under the rule.
	always_comb begin
		fits = loaded_q && !used_q && (size_q >= req_size);
		take = 1'b0;
		if (fits) begin
			if (!in_found) begin
				take = 1'b1;
			end else if (mode[1]) begin
				take = size_q > in_psize;
			end else if (mode == FIT_BEST) begin
				take = size_q < in_psize;
			end
		end
	end

	// Token valid moves one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// Candidate register handed to the neighbor.
	always_ff @(posedge clk) begin
		if (take) begin
			found_q <= 1'b1;
			pick_q  <= OWN_IDX;
			psize_q <= size_q;
		end else begin
			found_q <= in_found;
			pick_q  <= in_pick;
			psize_q <= in_psize;
		end
	end

	assign out_valid = valid_q;
	assign out_found = found_q;
	assign out_pick  = pick_q;
	assign out_psize = psize_q;

endmodule

// File: rtl/fixed_partition_fit_allocator.sv
// Fixed-partition fit allocator.
// Requests arrive on req (valid/ready). A load request writes the size of one
// partition slot, marks it loaded and free, and gives no response. A load to a
// slot at or beyond NUM_PARTS is dropped. An allocate request searches for a
// free loaded partition at least as large as the requested size, under the
// rule in the fit mode register (first, best or worst fit, ties to the lowest
// index), marks it used and gives one response on rsp: granted, block_index
// and the leftover fragment, or a refusal with zero fields.
// The search runs as a token through a row of NUM_PARTS cells, one cell per
// cycle; the outcome is registered from the last cell, then moved into the
// output register. One request is in work at a time.
// A finished response waits in the output register while the next request is
// taken; if the receiver stalls, a following allocate holds at the end of its
// search until the output register frees. Reset clears all loaded and used
// marks and sets the fit mode to best fit. The user writes the fit mode
// register (cfg_we, cfg_wdata) only while idle; the block does not enforce it.
`include "assert_macros.svh"

module fixed_partition_fit_allocator #(
	parameter int NUM_PARTS = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fpfa_pkg::MODE_W-1:0] cfg_wdata,
	fpfa_req_if.sink                    req,
	fpfa_rsp_if.source                  rsp
);
	import fpfa_pkg::*;

	localparam int IDX_W = $clog2(NUM_PARTS);
	localparam int EXT_W = (SIZE_BITS > VALUE_W) ? SIZE_BITS : VALUE_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	fit_mode_t            fit_mode_q;
	logic                 start_q;
	logic [SIZE_BITS-1:0] req_size_q;
	logic [SIZE_BITS-1:0] in_size;
	logic                 accept;
	logic                 load_en;
	logic [IDX_W-1:0]     load_idx;
	logic                 out_free;
	logic                 commit_en;
	logic                 fin_found_q;
	logic [IDX_W-1:0]     fin_pick_q;
	logic [SIZE_BITS-1:0] fin_psize_q;
	logic [SIZE_BITS-1:0] frag_diff;
	logic                 rsp_valid_q;
	logic                 rsp_granted_q;
	logic [SLOT_W-1:0]    rsp_index_q;
	logic [VALUE_W-1:0]   rsp_frag_q;

	logic                 chain_v     [NUM_PARTS+1];
	logic                 chain_found [NUM_PARTS+1];
	logic [IDX_W-1:0]     chain_pick  [NUM_PARTS+1];
	logic [SIZE_BITS-1:0] chain_psize [NUM_PARTS+1];
	logic [NUM_PARTS-1:0] token_vec;

	// Request decode.
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_size   = SIZE_BITS'(EXT_W'(req.size_value));
	assign load_en   = accept && (req.action == ACT_LOAD)
		&& (32'(req.slot_index) < NUM_PARTS);
	assign load_idx  = IDX_W'(req.slot_index);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign commit_en = (state_q == ST_DONE) && out_free && fin_found_q;

	// Fit mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_BEST;
		end else if (cfg_we) begin
			fit_mode_q <= cfg_wdata;
		end
	end

	// Control: idle, search running, result waiting for the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.action == ACT_ALLOC) begin
						start_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain_v[NUM_PARTS]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Requested size, held for the whole search.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_size_q <= in_size;
		end
	end

	// Search outcome taken from the last cell.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && chain_v[NUM_PARTS]) begin
			fin_found_q <= chain_found[NUM_PARTS];
			fin_pick_q  <= chain_found[NUM_PARTS] ? chain_pick[NUM_PARTS] : '0;
			fin_psize_q <= chain_psize[NUM_PARTS];
		end
	end

	// Row of cells; the token enters at cell zero with no candidate.
	assign chain_v[0]     = start_q;
	assign chain_found[0] = 1'b0;
	assign chain_pick[0]  = '0;
	assign chain_psize[0] = '0;

	for (genvar i = 0; i < NUM_PARTS; i++) begin : g_cell
		fpfa_cell #(
			.IDX_W    (IDX_W),
			.SIZE_BITS(SIZE_BITS),
			.MY_IDX   (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (load_en),
			.wr_idx    (load_idx),
			.wr_size   (in_size),
			.commit_en (commit_en),
			.commit_idx(fin_pick_q),
			.req_size  (req_size_q),
			.mode      (fit_mode_q),
			.in_valid  (chain_v[i]),
			.in_found  (chain_found[i]),
			.in_pick   (chain_pick[i]),
			.in_psize  (chain_psize[i]),
			.out_valid (chain_v[i+1]),
			.out_found (chain_found[i+1]),
			.out_pick  (chain_pick[i+1]),
			.out_psize (chain_psize[i+1])
		);
		assign token_vec[i] = chain_v[i+1];
	end

	// Leftover fragment, fitted to the response field width.
	assign frag_diff = fin_psize_q - req_size_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_granted_q <= fin_found_q;
			rsp_index_q   <= fin_found_q ? SLOT_W'(fin_pick_q) : '0;
			rsp_frag_q    <= fin_found_q ? VALUE_W'(EXT_W'(frag_diff)) : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.granted     = rsp_granted_q;
	assign rsp.block_index = rsp_index_q;
	assign rsp.fragment    = rsp_frag_q;

	// Checks on the search control.
	`ASSERT_PROP(a_start_scan, clk, arst_n, start_q |-> state_q == ST_SCAN, "start outside scan")
	`ASSERT_PROP(a_end_in_scan, clk, arst_n, token_vec[NUM_PARTS-1] |-> state_q == ST_SCAN,
		"token left the row outside scan")
	`ASSERT_PROP(a_one_token, clk, arst_n, $onehot0(token_vec), "more than one token in the row")
	`ASSERT_NEVER(a_idle_token, clk, arst_n, state_q == ST_IDLE && token_vec != '0,
		"token in the row while idle")
	`ASSERT_PROP(a_done_hold, clk, arst_n,
		(state_q == ST_DONE && !out_free) |=> state_q == ST_DONE, "result dropped on stall")

endmodule

// File: sim/fixed_partition_fit_allocator_tb.sv
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_tb;
	import fpfa_pkg::*;

	localparam int NUM_SLOTS = 16;
	localparam int SIZE_W = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 65;
	localparam int REPORT_MAX = 10;

	// The spare mode code, which the block treats as worst fit.
	localparam fit_mode_t FIT_SPARE = 2'd3;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [SLOT_W-1:0]   slot_index;
		logic [VALUE_W-1:0]  size_value;
	} alloc_req_t;

	typedef struct {
		logic               granted;
		logic [SLOT_W-1:0]  block_index;
		logic [VALUE_W-1:0] fragment;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	fit_mode_t cfg_wdata;

	fpfa_req_if req_ch ();
	fpfa_rsp_if rsp_ch ();

	fixed_partition_fit_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copy of the partition table and the fit mode.
	logic [SIZE_W-1:0] slot_size [NUM_SLOTS];
	logic              slot_loaded [NUM_SLOTS];
	logic              slot_taken [NUM_SLOTS];
	fit_mode_t         fit_sel;

	alloc_req_t pending_requests [$];
	grant_t     expected_grants [$];
	alloc_req_t on_wire;

	int requests_queued = 0;
	int requests_taken = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int take_idle_pct = 0;

	always #5 clk = ~clk;

	// Apply one accepted request to the shadow table and queue its grant, if any.
	function automatic void predict_request(input alloc_req_t r);
		bit found;
		int pick;
		grant_t g;
		found = 1'b0;
		pick = 0;
		if (r.action == ACT_LOAD) begin
			slot_size[r.slot_index] = r.size_value;
			slot_loaded[r.slot_index] = 1'b1;
			slot_taken[r.slot_index] = 1'b0;
			return;
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!slot_loaded[i] || slot_taken[i] || slot_size[i] < r.size_value)
				continue;
			if (!found) begin
				found = 1'b1;
				pick = i;
				if (fit_sel == FIT_FIRST)
					break;
			end else if (fit_sel[1]) begin
				// Worst fit: strictly larger wins, so ties stay at the lower index.
				if (slot_size[i] > slot_size[pick])
					pick = i;
			end else if (slot_size[i] < slot_size[pick]) begin
				pick = i;
			end
		end
		if (found) begin
			slot_taken[pick] = 1'b1;
			g.granted = 1'b1;
			g.block_index = pick[SLOT_W-1:0];
			g.fragment = slot_size[pick] - r.size_value;
		end else begin
			g.granted = 1'b0;
			g.block_index = '0;
			g.fragment = '0;
		end
		expected_grants.push_back(g);
	endfunction

	// Compare one accepted response with the oldest expected grant.
	function automatic void check_grant();
		grant_t g;
		if (expected_grants.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("response with nothing expected: granted=%0b index=%0d fragment=%0d",
					rsp_ch.granted, rsp_ch.block_index, rsp_ch.fragment);
			return;
		end
		g = expected_grants.pop_front();
		if (rsp_ch.granted !== g.granted || rsp_ch.block_index !== g.block_index ||
				rsp_ch.fragment !== g.fragment) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("grant mismatch: expected %0b/%0d/%0d, got %0b/%0d/%0d",
					g.granted, g.block_index, g.fragment,
					rsp_ch.granted, rsp_ch.block_index, rsp_ch.fragment);
		end
	endfunction

	function automatic alloc_req_t random_request();
		alloc_req_t r;
		int scale;
		scale = int'($urandom_range(3));
		r.action = ($urandom_range(99) < 45) ? ACT_LOAD : ACT_ALLOC;
		r.slot_index = SLOT_W'($urandom_range(NUM_SLOTS - 1));
		// Small sizes give many ties; the full range exercises every bit.
		case (scale)
			0: r.size_value = VALUE_W'($urandom);
			1: r.size_value = VALUE_W'($urandom_range(15));
			default: r.size_value = VALUE_W'($urandom_range(1023));
		endcase
		// Smaller requests than loads keep the grant rate up.
		if (r.action == ACT_ALLOC)
			r.size_value = r.size_value >> $urandom_range(2);
		return r;
	endfunction

	task automatic queue_request(input logic [ACTION_W-1:0] action,
			input int slot, input int size);
		alloc_req_t r;
		r.action = action;
		r.slot_index = SLOT_W'(slot);
		r.size_value = VALUE_W'(size);
		pending_requests.push_back(r);
		requests_queued++;
	endtask

	// Wait until every request is taken and every grant has come back.
	task automatic wait_drained();
		while (requests_taken != requests_queued || expected_grants.size() != 0)
			@(posedge clk);
		// A trailing load gives no response, so allow a full search to finish.
		repeat (NUM_SLOTS + 8) @(posedge clk);
	endtask

	task automatic write_fit_mode(input fit_mode_t m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		fit_sel = m;
	endtask

	// Request driver: holds a request until taken, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_request(on_wire);
				requests_taken++;
			end
			if (req_ch.valid && !req_ch.ready) begin
				// Stalled: keep the same request on the wire.
			end else if (pending_requests.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				on_wire = pending_requests.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.action <= on_wire.action;
				req_ch.slot_index <= on_wire.slot_index;
				req_ch.size_value <= on_wire.size_value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_grant();
			rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[fixed_partition_fit_allocator] ERROR");
			$finish;
		end
	end

	initial begin
		fit_mode_t phase_modes [6];
		phase_modes = '{FIT_FIRST, FIT_WORST, FIT_SPARE, FIT_BEST, FIT_FIRST, FIT_WORST};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = FIT_BEST;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_LOAD;
		req_ch.slot_index = '0;
		req_ch.size_value = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_size[i] = '0;
			slot_loaded[i] = 1'b0;
			slot_taken[i] = 1'b0;
		end
		fit_sel = FIT_BEST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset mode (best fit).
		send_idle_pct = 31;
		take_idle_pct = 49;
		queue_request(ACT_ALLOC, 0, 0);        // empty table: refusal
		queue_request(ACT_LOAD, 0, 0);
		queue_request(ACT_LOAD, 15, 65535);
		queue_request(ACT_LOAD, 5, 100);
		queue_request(ACT_LOAD, 9, 100);
		queue_request(ACT_ALLOC, 7, 0);        // zero request fits the zero-size slot
		queue_request(ACT_ALLOC, 0, 50);       // tie between two slots goes low
		queue_request(ACT_ALLOC, 0, 100);
		queue_request(ACT_ALLOC, 0, 65535);
		queue_request(ACT_ALLOC, 0, 1);        // everything used: refusal
		queue_request(ACT_LOAD, 15, 65535);    // reload frees a used slot
		queue_request(ACT_LOAD, 5, 16'h5555);
		queue_request(ACT_LOAD, 10, 16'hAAAA);
		queue_request(ACT_ALLOC, 0, 16'h5555);
		queue_request(ACT_ALLOC, 0, 0);
		queue_request(ACT_ALLOC, 0, 0);        // largest fragment
		queue_request(ACT_ALLOC, 0, 65535);

		// Random phases, each under the fit mode and idle pattern set for it.
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			if (ph < 2) begin
				send_idle_pct = 31;
				take_idle_pct = 49;
			end else if (ph < 4) begin
				send_idle_pct = 49;
				take_idle_pct = 31;
			end else begin
				send_idle_pct = 0;
				take_idle_pct = 0;
			end
			write_fit_mode(phase_modes[ph]);
			for (int n = 0; n < 2 * PHASE_ITEMS; n++) begin
				// Halfway through, hold off until all grants are back.
				if (n == PHASE_ITEMS)
					wait_drained();
				pending_requests.push_back(random_request());
				requests_queued++;
			end
		end
		wait_drained();

		if (expected_grants.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("[fixed_partition_fit_allocator] OK");
		end else begin
			$display("[fixed_partition_fit_allocator] ERROR");
		end
		$finish;
	end

endmodule
